// File: design/b64enc_pkg.sv
// Shared types, request codes and the character table of the base64 stream encoder.
// No dependencies; every other file of the block imports this package.
package b64enc_pkg;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_DATA  = 2'd0,
      REQ_FINAL = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // One encoding job: a 24-bit group and the number of trailing pad characters.
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pads;
   } job_type;

   // Maps a sextet to its character of the standard alphabet.
   function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
      logic [7:0] code;
      code = {2'b00, sextet};
      if (sextet < 6'd26) begin
         sextet_char = code + 8'd65;
      end else if (sextet < 6'd52) begin
         sextet_char = code + 8'd71;
      end else if (sextet < 6'd62) begin
         sextet_char = code - 8'd4;
      end else if (sextet == 6'd62) begin
         sextet_char = 8'h2B;
      end else begin
         sextet_char = 8'h2F;
      end
   endfunction

endpackage

// File: design/b64enc_front.sv
// Front end of the base64 stream encoder: accepts requests, holds bytes, forms jobs.
// Depends on b64enc_pkg.
module b64enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_code,
   input  logic [7:0]            req_byte,
   output logic                  job_push,
   output b64enc_pkg::job_type   job_data
);
   import b64enc_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic       push_int;
   job_type    job_int;

   // Classify each transaction and update the held bytes.
   always_comb begin
      held_count_in = held_count_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      push_int      = 1'b0;
      job_int.group = {held0_ff, held1_ff, req_byte};
      job_int.pads  = 2'd0;
      if (req_valid) begin
         case (req_code)
            REQ_DATA: begin
               if (held_count_ff == 2'd0) begin
                  held0_in      = req_byte;
                  held_count_in = 2'd1;
               end else if (held_count_ff == 2'd1) begin
                  held1_in      = req_byte;
                  held_count_in = 2'd2;
               end else begin
                  push_int      = 1'b1;
                  held_count_in = 2'd0;
               end
            end
            REQ_FINAL: begin
               if (held_count_ff != 2'd0) begin
                  push_int      = 1'b1;
                  held_count_in = 2'd0;
                  if (held_count_ff == 2'd1) begin
                     job_int.group = {held0_ff, 16'd0};
                     job_int.pads  = 2'd2;
                  end else begin
                     job_int.group = {held0_ff, held1_ff, 8'd0};
                     job_int.pads  = 2'd1;
                  end
               end
            end
            REQ_CLEAR: begin
               held_count_in = 2'd0;
            end
            default: begin
               held_count_in = held_count_ff;
            end
         endcase
      end
   end

   assign job_push = push_int;
   assign job_data = job_int;

   // Held count is control state; the held bytes need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

   // The held count never reaches three.
   assert property (@(posedge clock) disable iff (reset) held_count_ff != 2'd3)
      else $error("held count out of range");

   // A pushed job always empties the held bytes.
   assert property (@(posedge clock) disable iff (reset) job_push |=> held_count_ff == 2'd0)
      else $error("held count not cleared after a job");

endmodule

// File: design/b64enc_queue.sv
// Short job queue between the front and back ends of the base64 stream encoder.
// Depends on b64enc_pkg.
module b64enc_queue #(
   parameter int unsigned Depth = b64enc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::job_type   push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output b64enc_pkg::job_type   head_data
);
   import b64enc_pkg::*;

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   job_type                entries_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign head_data = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front end never offers a job while the queue is full.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job offered to a full queue");

   // Occupancy stays within the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCount)
      else $error("queue occupancy overflow");

endmodule

// File: design/b64enc_back.sv
// Back end of the base64 stream encoder: turns each job into four characters.
// Depends on b64enc_pkg.
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_ready,
   input  b64enc_pkg::job_type   job_data,
   output logic                  job_take,
   output logic                  rsp_valid,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_char,
   output logic                  rsp_last
);
   import b64enc_pkg::*;

   job_type    job_ff, job_in;
   logic       job_valid_ff, job_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       out_load, job_done;
   logic [5:0] sextet;
   logic       is_pad;

   assign out_load = !out_valid_ff || rsp_pop;
   assign job_done = job_valid_ff && out_load && (idx_ff == 2'd3);
   assign job_take = job_ready && (!job_valid_ff || job_done);

   // Select the sextet for the current position, most significant first.
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = job_ff.group[23:18];
         2'd1:    sextet = job_ff.group[17:12];
         2'd2:    sextet = job_ff.group[11:6];
         default: sextet = job_ff.group[5:0];
      endcase
      is_pad = ((idx_ff == 2'd3) && (job_ff.pads != 2'd0)) ||
               ((idx_ff == 2'd2) && (job_ff.pads == 2'd2));
   end

   // Job register, position counter and output register.
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = job_valid_ff;
         out_char_in  = is_pad ? PAD_CHAR : sextet_char(sextet);
         out_last_in  = (idx_ff == 2'd3);
         if (job_valid_ff) begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (job_done) begin
         job_valid_in = 1'b0;
      end
      if (job_take) begin
         job_in       = job_data;
         job_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      job_ff      <= job_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;

   // The fourth character of a job is marked as the last of its group.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && job_valid_ff && idx_ff == 2'd3) |=> (out_valid_ff && out_last_ff))
      else $error("last flag missing on fourth character");

   // A new job is only taken when the current one is absent or finishing.
   assert property (@(posedge clock) disable iff (reset)
      (job_take && job_valid_ff) |-> (idx_ff == 2'd3 && out_load))
      else $error("job overwritten before completion");

endmodule

// File: design/base64_stream_encoder.sv
// Base64 stream encoder: a group of three bytes yields four characters.
// Throughput: one character per cycle at the output register while pop takes each one, so
// the four-character serialiser sets the rate for a group of three data transactions.
// A group's first character passes the queue, the job register and the output register in turn.
// Reset (synchronous, active high) clears held count, queue and output; held bytes keep data.
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
module base64_stream_encoder #(
   parameter int unsigned QueueDepth = b64enc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last
);
   import b64enc_pkg::*;

   logic    q_full;
   logic    job_push;
   job_type job_new;
   logic    q_not_empty;
   job_type q_head;
   logic    q_pop;
   logic    out_valid;

   assign full = q_full;

   // Front end: request classification and byte holding.
   b64enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (push && !q_full),
      .req_code  (req_type),
      .req_byte  (req_data_byte),
      .job_push  (job_push),
      .job_data  (job_new)
   );

   // Job queue decoupling the two ends.
   b64enc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_new),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   // Back end: character serialiser with output register.
   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (q_not_empty),
      .job_data  (q_head),
      .job_take  (q_pop),
      .rsp_valid (out_valid),
      .rsp_pop   (pop),
      .rsp_char  (rsp_out_char),
      .rsp_last  (rsp_run_last)
   );

   assign empty = !out_valid;

endmodule
